### hdl/ttf_pkg.sv
`timescale 1ns / 1ps
package ttf_pkg;

  localparam int COORD_FRAC_BITS = 16;
  localparam int COORD_W = 32;
  localparam int NRM_W = 16;
  localparam int FLOOR_W = 16;
  localparam logic [FLOOR_W-1:0] DET_FLOOR_RESET = 16'd4295;
  localparam bit FLOOR_LEFT = (2 * COORD_FRAC_BITS >= 32);
  localparam int FLOOR_SH = FLOOR_LEFT ? (2 * COORD_FRAC_BITS - 32)
                                       : (32 - 2 * COORD_FRAC_BITS);
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS = 16;
  localparam int ONE_Q14 = 16384;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic signed [COORD_W-1:0] tex_u;
    logic signed [COORD_W-1:0] tex_v;
    logic signed [NRM_W-1:0]   norm_x;
    logic signed [NRM_W-1:0]   norm_y;
    logic signed [NRM_W-1:0]   norm_z;
  } vtx_t;

  typedef struct packed {
    logic signed [NRM_W-1:0] tan_x;
    logic signed [NRM_W-1:0] tan_y;
    logic signed [NRM_W-1:0] tan_z;
    logic                    mirrored;
    logic                    last;
  } tan_t;

  typedef struct packed {
    logic       cap;
    logic       edg;
    logic       prd;
    logic       cmb;
    logic       nstep;
    logic       savet;
    logic       saveb;
    logic       dot;
    logic       gld;
    logic       sq;
    logic       sqs;
    logic       dvi;
    logic       dvs;
    logic       crs;
    logic       hnd;
    logic       emit;
    logic [1:0] slot;
    logic [1:0] vtx;
    logic [4:0] cnt;
  } cmd_t;

  typedef struct packed {
    logic nm_done;
    logic out_free;
  } sts_t;

endpackage

### hdl/ttf_if.sv
`timescale 1ns / 1ps
interface ttf_vtx_if;
  import ttf_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic signed [COORD_W-1:0] pos_z;
  logic signed [COORD_W-1:0] tex_u;
  logic signed [COORD_W-1:0] tex_v;
  logic signed [NRM_W-1:0]   norm_x;
  logic signed [NRM_W-1:0]   norm_y;
  logic signed [NRM_W-1:0]   norm_z;
  modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z,
                  input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z,
                output ready);
endinterface

interface ttf_tan_if;
  import ttf_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [NRM_W-1:0] tan_x;
  logic signed [NRM_W-1:0] tan_y;
  logic signed [NRM_W-1:0] tan_z;
  logic                    mirrored;
  logic                    last;
  modport source (output valid, tan_x, tan_y, tan_z, mirrored, last, input ready);
  modport sink (input valid, tan_x, tan_y, tan_z, mirrored, last, output ready);
endinterface

interface ttf_cfg_if;
  import ttf_pkg::*;
  logic               valid;
  logic               ready;
  logic [FLOOR_W-1:0] det_floor;
  modport source (output valid, det_floor, input ready);
  modport sink (input valid, det_floor, output ready);
endinterface

### hdl/ttf_ctrl.sv
`timescale 1ns / 1ps
module ttf_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output ttf_pkg::cmd_t cmd,
  input  ttf_pkg::sts_t sts
);
  import ttf_pkg::*;

  typedef enum logic [15:0] {
    S_IN    = 16'h0001,
    S_EDGE  = 16'h0002,
    S_PROD  = 16'h0004,
    S_COMB  = 16'h0008,
    S_NT    = 16'h0010,
    S_NB    = 16'h0020,
    S_DOT   = 16'h0040,
    S_G     = 16'h0080,
    S_NG    = 16'h0100,
    S_SQ    = 16'h0200,
    S_SQRT  = 16'h0400,
    S_DIVI  = 16'h0800,
    S_DIV   = 16'h1000,
    S_CROSS = 16'h2000,
    S_HAND  = 16'h4000,
    S_EMIT  = 16'h8000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] slot_r, slot_nxt;
  logic [1:0] vtx_r, vtx_nxt;
  logic [4:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IN;
      slot_r  <= '0;
      vtx_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      slot_r  <= slot_nxt;
      vtx_r   <= vtx_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    slot_nxt  = slot_r;
    vtx_nxt   = vtx_r;
    cnt_nxt   = cnt_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.slot  = slot_r;
    cmd.vtx   = vtx_r;
    cmd.cnt   = cnt_r;
    case (state_r)
      S_IN: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap = 1'b1;
          if (slot_r == 2'd2) begin
            slot_nxt  = '0;
            state_nxt = S_EDGE;
          end else begin
            slot_nxt = slot_r + 2'd1;
          end
        end
      end
      S_EDGE: begin
        cmd.edg   = 1'b1;
        state_nxt = S_PROD;
      end
      S_PROD: begin
        cmd.prd   = 1'b1;
        state_nxt = S_COMB;
      end
      S_COMB: begin
        cmd.cmb   = 1'b1;
        state_nxt = S_NT;
      end
      S_NT: begin
        if (sts.nm_done) begin
          cmd.savet = 1'b1;
          state_nxt = S_NB;
        end else begin
          cmd.nstep = 1'b1;
        end
      end
      S_NB: begin
        if (sts.nm_done) begin
          cmd.saveb = 1'b1;
          vtx_nxt   = '0;
          state_nxt = S_DOT;
        end else begin
          cmd.nstep = 1'b1;
        end
      end
      S_DOT: begin
        cmd.dot   = 1'b1;
        state_nxt = S_G;
      end
      S_G: begin
        cmd.gld   = 1'b1;
        state_nxt = S_NG;
      end
      S_NG: begin
        if (sts.nm_done) begin
          state_nxt = S_SQ;
        end else begin
          cmd.nstep = 1'b1;
        end
      end
      S_SQ: begin
        cmd.sq    = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqs = 1'b1;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(SQRT_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_DIVI;
        end
      end
      S_DIVI: begin
        cmd.dvi   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.dvs = 1'b1;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(DIV_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_CROSS;
        end
      end
      S_CROSS: begin
        cmd.crs   = 1'b1;
        state_nxt = S_HAND;
      end
      S_HAND: begin
        cmd.hnd   = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (vtx_r == 2'd2) begin
            vtx_nxt   = '0;
            state_nxt = S_IN;
          end else begin
            vtx_nxt   = vtx_r + 2'd1;
            state_nxt = S_DOT;
          end
        end
      end
      default: begin
        state_nxt = S_IN;
      end
    endcase
  end

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free) else $error("emit while result register busy");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r != 2'd3 && vtx_r != 2'd3) else $error("vertex index out of range");

  a_third_vertex: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IN && in_valid && slot_r == 2'd2) |=> (state_r == S_EDGE && slot_r == 2'd0))
    else $error("third vertex did not start triangle");

  a_tri_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && vtx_r == 2'd2 && sts.out_free) |=> (state_r == S_IN))
    else $error("triangle did not return to input");

endmodule

### hdl/ttf_dp.sv
`timescale 1ns / 1ps
module ttf_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ttf_pkg::cmd_t                cmd,
  output ttf_pkg::sts_t                sts,
  input  ttf_pkg::vtx_t                vtx,
  input  logic                         cfg_valid,
  input  logic [ttf_pkg::FLOOR_W-1:0]  cfg_data,
  output ttf_pkg::tan_t                res,
  output logic                         res_valid,
  input  logic                         res_ready
);
  import ttf_pkg::*;

  function automatic logic signed [COORD_W-1:0] sat_sub(input logic signed [COORD_W-1:0] a,
                                                        input logic signed [COORD_W-1:0] b);
    logic signed [COORD_W:0] d;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    if (d[COORD_W] != d[COORD_W-1]) begin
      return d[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end
    return d[COORD_W-1:0];
  endfunction

  function automatic logic [63:0] mag64(input logic signed [64:0] v);
    logic signed [64:0] a;
    a = v[64] ? -v : v;
    return a[63:0];
  endfunction

  function automatic logic signed [30:0] to_s31(input logic [63:0] m, input logic n);
    logic signed [30:0] v;
    v = $signed(m[30:0]);
    return n ? -v : v;
  endfunction

  logic signed [COORD_W-1:0] pos_r [3][3];
  logic signed [COORD_W-1:0] uv_r  [3][2];
  logic signed [NRM_W-1:0]   nrm_r [3][3];
  logic signed [COORD_W-1:0] e1_r [3];
  logic signed [COORD_W-1:0] e2_r [3];
  logic signed [COORD_W-1:0] du1_r, dv1_r, du2_r, dv2_r;
  logic signed [63:0]        pa_r, pb_r;
  logic signed [63:0]        ta_r [3];
  logic signed [63:0]        tb_r [3];
  logic signed [63:0]        ba_r [3];
  logic signed [63:0]        bb_r [3];
  logic signed [64:0]        bv_r [3];
  logic                      neg_r;
  logic [63:0]               nm_mag_r [3];
  logic                      nm_neg_r [3];
  logic signed [30:0]        ts_r [3];
  logic signed [30:0]        bs_r [3];
  logic signed [48:0]        dot_r;
  logic [63:0]               sqx_r, sqr_r;
  logic [30:0]               len_r;
  logic                      lenz_r;
  logic [46:0]               rem_r [3];
  logic [15:0]               q_r [3];
  logic signed [NRM_W-1:0]   tout_r [3];
  logic signed [31:0]        c_r [3];
  logic signed [63:0]        hp_r [3];
  logic [FLOOR_W-1:0]        det_floor_r;
  tan_t                      res_r;
  logic                      res_valid_r, res_valid_nxt;

  logic signed [64:0]        det_w, fl_w;
  logic                      neg_w;
  logic signed [64:0]        t_w [3];
  logic signed [64:0]        g_w [3];
  logic signed [64:0]        ld_w [3];
  logic signed [NRM_W-1:0]   nk_w [3];
  logic [63:0]               top_w;
  logic [5:0]                sh_w;
  logic [63:0]               bit_w, trial_w;
  logic [46:0]               dcmp_w;
  logic [15:0]               qc_w [3];
  logic signed [NRM_W-1:0]   tout_w [3];
  logic signed [65:0]        h_w;
  logic                      mir_w;

  always_comb begin
    det_w = 65'(pa_r) - 65'(pb_r);
    if (FLOOR_LEFT) begin
      fl_w = 65'(det_floor_r) << FLOOR_SH;
    end else begin
      fl_w = 65'(det_floor_r) >> FLOOR_SH;
      if (fl_w == 65'sd0) fl_w = 65'sd1;
    end
    neg_w = (det_w <= -fl_w);
    for (int i = 0; i < 3; i++) begin
      nk_w[i] = nrm_r[cmd.vtx][i];
      t_w[i]  = 65'(ta_r[i]) - 65'(tb_r[i]);
      if (neg_w) t_w[i] = -t_w[i];
      g_w[i]  = (65'(ts_r[i]) <<< 28) - dot_r * nk_w[i];
      if (cmd.cmb) begin
        ld_w[i] = t_w[i];
      end else if (cmd.savet) begin
        ld_w[i] = bv_r[i];
      end else begin
        ld_w[i] = g_w[i];
      end
    end
    top_w = nm_mag_r[0];
    if (nm_mag_r[1] > top_w) top_w = nm_mag_r[1];
    if (nm_mag_r[2] > top_w) top_w = nm_mag_r[2];
    sh_w    = 6'd62 - {cmd.cnt, 1'b0};
    bit_w   = 64'd1 << sh_w;
    trial_w = sqr_r + bit_w;
    dcmp_w  = 47'(len_r) << (4'd15 - cmd.cnt[3:0]);
    for (int i = 0; i < 3; i++) begin
      qc_w[i] = (q_r[i] > 16'(ONE_Q14)) ? 16'(ONE_Q14) : q_r[i];
      if (lenz_r) begin
        tout_w[i] = '0;
      end else begin
        tout_w[i] = nm_neg_r[i] ? -$signed(qc_w[i]) : $signed(qc_w[i]);
      end
    end
    h_w   = 66'(hp_r[0]) + 66'(hp_r[1]) + 66'(hp_r[2]);
    mir_w = lenz_r ? 1'b0 : (neg_r ? (h_w > 66'sd0) : (h_w < 66'sd0));
  end

  assign sts.nm_done  = (top_w == 64'd0) || (top_w[63:30] == '0 && top_w[29]);
  assign sts.out_free = !res_valid_r || res_ready;

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      pos_r[cmd.slot][0] <= vtx.pos_x;
      pos_r[cmd.slot][1] <= vtx.pos_y;
      pos_r[cmd.slot][2] <= vtx.pos_z;
      uv_r[cmd.slot][0]  <= vtx.tex_u;
      uv_r[cmd.slot][1]  <= vtx.tex_v;
      nrm_r[cmd.slot][0] <= vtx.norm_x;
      nrm_r[cmd.slot][1] <= vtx.norm_y;
      nrm_r[cmd.slot][2] <= vtx.norm_z;
    end
    if (cmd.edg) begin
      for (int i = 0; i < 3; i++) begin
        e1_r[i] <= sat_sub(pos_r[1][i], pos_r[0][i]);
        e2_r[i] <= sat_sub(pos_r[2][i], pos_r[0][i]);
      end
      du1_r <= sat_sub(uv_r[1][0], uv_r[0][0]);
      dv1_r <= sat_sub(uv_r[1][1], uv_r[0][1]);
      du2_r <= sat_sub(uv_r[2][0], uv_r[0][0]);
      dv2_r <= sat_sub(uv_r[2][1], uv_r[0][1]);
    end
    if (cmd.prd) begin
      pa_r <= du1_r * dv2_r;
      pb_r <= dv1_r * du2_r;
      for (int i = 0; i < 3; i++) begin
        ta_r[i] <= dv2_r * e1_r[i];
        tb_r[i] <= dv1_r * e2_r[i];
        ba_r[i] <= du1_r * e2_r[i];
        bb_r[i] <= du2_r * e1_r[i];
      end
    end
    if (cmd.cmb) begin
      neg_r <= neg_w;
      for (int i = 0; i < 3; i++) begin
        bv_r[i] <= 65'(ba_r[i]) - 65'(bb_r[i]);
      end
    end
    for (int i = 0; i < 3; i++) begin
      if (cmd.cmb || cmd.savet || cmd.gld) begin
        nm_mag_r[i] <= mag64(ld_w[i]);
        nm_neg_r[i] <= ld_w[i][64];
      end else if (cmd.nstep) begin
        if (top_w[63:34] != '0) begin
          nm_mag_r[i] <= nm_mag_r[i] >> 4;
        end else if (top_w[63:30] != '0) begin
          nm_mag_r[i] <= nm_mag_r[i] >> 1;
        end else if (top_w[63:25] == '0) begin
          nm_mag_r[i] <= nm_mag_r[i] << 4;
        end else begin
          nm_mag_r[i] <= nm_mag_r[i] << 1;
        end
      end
      if (cmd.savet) ts_r[i] <= to_s31(nm_mag_r[i], nm_neg_r[i]);
      if (cmd.saveb) bs_r[i] <= to_s31(nm_mag_r[i], nm_neg_r[i]);
    end
    if (cmd.dot) begin
      dot_r <= ts_r[0] * nk_w[0] + ts_r[1] * nk_w[1] + ts_r[2] * nk_w[2];
    end
    if (cmd.sq) begin
      sqx_r <= nm_mag_r[0][29:0] * nm_mag_r[0][29:0] + nm_mag_r[1][29:0] * nm_mag_r[1][29:0]
             + nm_mag_r[2][29:0] * nm_mag_r[2][29:0];
      sqr_r <= '0;
    end else if (cmd.sqs) begin
      if (sqx_r >= trial_w) begin
        sqx_r <= sqx_r - trial_w;
        sqr_r <= (sqr_r >> 1) + bit_w;
      end else begin
        sqr_r <= sqr_r >> 1;
      end
    end
    if (cmd.dvi) begin
      len_r  <= sqr_r[30:0];
      lenz_r <= (sqr_r[30:0] == '0);
    end
    for (int i = 0; i < 3; i++) begin
      if (cmd.dvi) begin
        rem_r[i] <= 47'({nm_mag_r[i][29:0], 14'b0}) + 47'(sqr_r[30:1]);
        q_r[i]   <= '0;
      end else if (cmd.dvs) begin
        if (rem_r[i] >= dcmp_w) begin
          rem_r[i] <= rem_r[i] - dcmp_w;
          q_r[i]   <= {q_r[i][14:0], 1'b1};
        end else begin
          q_r[i]   <= {q_r[i][14:0], 1'b0};
        end
      end
    end
    if (cmd.crs) begin
      for (int i = 0; i < 3; i++) tout_r[i] <= tout_w[i];
      c_r[0] <= nk_w[1] * tout_w[2] - nk_w[2] * tout_w[1];
      c_r[1] <= nk_w[2] * tout_w[0] - nk_w[0] * tout_w[2];
      c_r[2] <= nk_w[0] * tout_w[1] - nk_w[1] * tout_w[0];
    end
    if (cmd.hnd) begin
      for (int i = 0; i < 3; i++) hp_r[i] <= c_r[i] * bs_r[i];
    end
    if (cmd.emit) begin
      res_r.tan_x    <= tout_r[0];
      res_r.tan_y    <= tout_r[1];
      res_r.tan_z    <= tout_r[2];
      res_r.mirrored <= mir_w;
      res_r.last     <= (cmd.vtx == 2'd2);
    end
  end

  always_comb begin
    res_valid_nxt = res_valid_r;
    if (cmd.emit) begin
      res_valid_nxt = 1'b1;
    end else if (res_ready) begin
      res_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
      det_floor_r <= DET_FLOOR_RESET;
    end else begin
      res_valid_r <= res_valid_nxt;
      if (cfg_valid) det_floor_r <= cfg_data;
    end
  end

  assign res       = res_r;
  assign res_valid = res_valid_r;

endmodule

### hdl/triangle_tangent_frame_top.sv
`timescale 1ns / 1ps
// Per-triangle tangent frame generator.
// in_ch takes unindexed vertices (position, UV, normal), three per triangle.
// The first two are held; the third starts the triangle computation and
// out_ch then delivers three tangent items, vertex 0, 1, 2, with last set
// on the third. cfg_ch writes det_floor and is always ready;
// write it only while no triangle is in flight.
// The third vertex starts the triangle setup, then the tangent and
// bitangent normalize passes, then a pass per vertex dominated by the
// 32-step square root and the 16-step restoring dividers.
// in_ch is not ready while a triangle computes.
// A single output register holds each result; if out_ch stalls, the
// sequencer waits before loading the next one and the last result may
// stay pending while the next vertices are accepted.
// Synchronous active-low reset clears the vertex count, the sequencer, the
// output valid and sets det_floor to 4295.
module triangle_tangent_frame_top (
  input logic      clk,
  input logic      rst_n,
  ttf_cfg_if.sink  cfg_ch,
  ttf_vtx_if.sink  in_ch,
  ttf_tan_if.source out_ch
);
  import ttf_pkg::*;

  cmd_t cmd;
  sts_t sts;
  vtx_t vtx;
  tan_t res;
  logic res_valid;
  logic in_ready;

  always_comb begin
    vtx.pos_x  = in_ch.pos_x;
    vtx.pos_y  = in_ch.pos_y;
    vtx.pos_z  = in_ch.pos_z;
    vtx.tex_u  = in_ch.tex_u;
    vtx.tex_v  = in_ch.tex_v;
    vtx.norm_x = in_ch.norm_x;
    vtx.norm_y = in_ch.norm_y;
    vtx.norm_z = in_ch.norm_z;
  end

  assign in_ch.ready     = in_ready;
  assign cfg_ch.ready    = 1'b1;
  assign out_ch.valid    = res_valid;
  assign out_ch.tan_x    = res.tan_x;
  assign out_ch.tan_y    = res.tan_y;
  assign out_ch.tan_z    = res.tan_z;
  assign out_ch.mirrored = res.mirrored;
  assign out_ch.last     = res.last;

  ttf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  ttf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .vtx       (vtx),
    .cfg_valid (cfg_ch.valid),
    .cfg_data  (cfg_ch.det_floor),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (out_ch.ready)
  );

endmodule
